>>> rtl/lbm_pkg.sv
// package: widths, fixed-point constants and saturating arithmetic helpers
`default_nettype none
package lbm_pkg;
   localparam int DataWidth = 32;
   localparam int FracBits  = 28;
   localparam int RateWidth = 30;
   localparam int DensWidth = 31;
   localparam int NumDir    = 9;
   localparam int Stages    = 14;

   // lattice directions and opposite directions
   localparam int DX [NumDir] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   localparam int DY [NumDir] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
   localparam int OPP[NumDir] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};

   typedef logic signed [DataWidth-1:0] data_type;
   typedef logic [1:0] csr_addr_type;

   localparam csr_addr_type CsrEvenRate = 2'd0;
   localparam csr_addr_type CsrOddRate  = 2'd1;
   localparam csr_addr_type CsrRestDens = 2'd2;
   localparam csr_addr_type CsrInvRest  = 2'd3;

   localparam longint OneQ = longint'(1) << FracBits;
   localparam data_type KW0 = data_type'((4 * OneQ + 4) / 9);
   localparam data_type KW1 = data_type'((OneQ + 4) / 9);
   localparam data_type KW2 = data_type'((OneQ + 18) / 36);
   localparam data_type KThree     = data_type'(3 * OneQ);
   localparam data_type KNineHalf  = data_type'(9 * (OneQ >> 1));
   localparam data_type KThreeHalf = data_type'(3 * (OneQ >> 1));

   localparam data_type VMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam data_type VMin = {1'b1, {(DataWidth-1){1'b0}}};

   // clamp a one-bit-wider sum into range
   function automatic data_type sat1(input logic signed [DataWidth:0] v);
      data_type r;
      if (v[DataWidth] != v[DataWidth-1]) r = v[DataWidth] ? VMin : VMax;
      else r = v[DataWidth-1:0];
      return r;
   endfunction

   function automatic data_type sadd(input data_type a, input data_type b);
      logic signed [DataWidth:0] s;
      s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
      return sat1(s);
   endfunction

   function automatic data_type ssub(input data_type a, input data_type b);
      logic signed [DataWidth:0] s;
      s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
      return sat1(s);
   endfunction

   // product with round half away from zero and saturation
   function automatic data_type smul(input data_type a, input data_type b);
      logic signed [2*DataWidth-1:0] p;
      logic [2*DataWidth-1:0] m;
      logic [2*DataWidth-1:0] q;
      logic neg;
      data_type r;
      p = a * b;
      neg = p[2*DataWidth-1];
      m = neg ? (~p + 1'b1) : p;
      q = (m + (64'(1) << (FracBits-1))) >> FracBits;
      if (!neg) r = (q > 64'(VMax)) ? VMax : q[DataWidth-1:0];
      else if (q >= 64'(VMax) + 64'd1) r = VMin;
      else r = data_type'(-q[DataWidth-1:0]);
      return r;
   endfunction

   // half a value, rounded the same way
   function automatic data_type shalf(input data_type a);
      logic signed [DataWidth:0] e;
      logic [DataWidth:0] m;
      logic [DataWidth:0] q;
      e = {a[DataWidth-1], a};
      m = a[DataWidth-1] ? (~e + 1'b1) : e;
      q = (m + 1'b1) >> 1;
      return a[DataWidth-1] ? data_type'(-q[DataWidth-1:0]) : q[DataWidth-1:0];
   endfunction
endpackage
`default_nettype wire

>>> rtl/lbm_intf.sv
// handshake interfaces for node items, results and register writes
`default_nettype none
interface lbm_node_if import lbm_pkg::*; ();
   logic valid;
   logic ready;
   data_type dist_rest, dist_east, dist_north, dist_west, dist_south;
   data_type dist_ne, dist_nw, dist_sw, dist_se;
   modport source(output valid, dist_rest, dist_east, dist_north, dist_west, dist_south,
                  dist_ne, dist_nw, dist_sw, dist_se, input ready);
   modport sink(input valid, dist_rest, dist_east, dist_north, dist_west, dist_south,
                dist_ne, dist_nw, dist_sw, dist_se, output ready);
endinterface

interface lbm_post_if import lbm_pkg::*; ();
   logic valid;
   logic ready;
   data_type post_rest, post_east, post_north, post_west, post_south;
   data_type post_ne, post_nw, post_sw, post_se, density, momentum_x, momentum_y;
   modport source(output valid, post_rest, post_east, post_north, post_west, post_south,
                  post_ne, post_nw, post_sw, post_se, density, momentum_x, momentum_y,
                  input ready);
   modport sink(input valid, post_rest, post_east, post_north, post_west, post_south,
                post_ne, post_nw, post_sw, post_se, density, momentum_x, momentum_y,
                output ready);
endinterface

interface lbm_csr_if import lbm_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [DataWidth-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/lbm_d2q9_trt_collision_core.sv
// top level: pipelined d2q9 two-relaxation-time collision
//
// channel | port   | direction | content
// req     | req_if | in        | nine distributions of one node
// rsp     | rsp_if | out       | nine post-collision values, density, momentum
// csr     | csr_if | in        | register index and write data
//
// one item per cycle while the pipeline is not stalled; 14 register stages
// each stage holds one multiplier level or a short run of saturating adds;
// the ordered nine-term moment sums are split over the first two stages
// reset clears the valid bits and loads the default register values
// a stall freezes the whole pipeline; req ready drops only while a result waits
`default_nettype none
module lbm_d2q9_trt_collision_core import lbm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   lbm_node_if.sink req_if,
   lbm_post_if.source rsp_if,
   lbm_csr_if.sink csr_if
);
   // configuration registers
   data_type even_ff, odd_ff, rho0_ff, inv_ff;
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         even_ff <= -data_type'(268435456);
         odd_ff  <= -data_type'(306783378);
         rho0_ff <= data_type'(268435456);
         inv_ff  <= data_type'(268435456);
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CsrEvenRate: even_ff <= data_type'(signed'(csr_if.data[RateWidth-1:0]));
            CsrOddRate:  odd_ff  <= data_type'(signed'(csr_if.data[RateWidth-1:0]));
            CsrRestDens: rho0_ff <= data_type'({1'b0, csr_if.data[DensWidth-1:0]});
            CsrInvRest:  inv_ff  <= data_type'({1'b0, csr_if.data[DensWidth-1:0]});
            default: ;
         endcase
      end
   end

   // pipeline enable: whole pipe moves when the output slot is free
   logic adv;
   logic [Stages-1:0] vld_ff;
   assign adv = !vld_ff[Stages-1] || rsp_if.ready;
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Stages-2:0], req_if.valid};
   end

   // per-stage payload
   data_type f_ff   [Stages][NumDir];
   data_type rho_ff [Stages];
   data_type jx_ff  [Stages];
   data_type jy_ff  [Stages];
   data_type ux_ff  [Stages];
   data_type uy_ff  [Stages];
   data_type uu_ff  [Stages];
   data_type a_ff   [Stages][NumDir];
   data_type b_ff   [Stages][NumDir];

   function automatic data_type wgt(input int k);
      data_type w;
      if (k == 0) w = KW0;
      else if (k < 5) w = KW1;
      else w = KW2;
      return w;
   endfunction

   data_type f_in   [Stages][NumDir];
   data_type a_in   [Stages][NumDir];
   data_type b_in   [Stages][NumDir];
   data_type rho_in [Stages];
   data_type jx_in  [Stages];
   data_type jy_in  [Stages];
   data_type ux_in  [Stages];
   data_type uy_in  [Stages];
   data_type uu_in  [Stages];

   // stage logic, one product depth per stage
   always_comb begin
      data_type r, x, y;
      for (int s = 0; s < Stages; s++) begin
         if (s == 0) begin
            f_in[0] = '{req_if.dist_rest, req_if.dist_east, req_if.dist_north,
                        req_if.dist_west, req_if.dist_south, req_if.dist_ne,
                        req_if.dist_nw, req_if.dist_sw, req_if.dist_se};
            rho_in[0] = '0; jx_in[0] = '0; jy_in[0] = '0;
            ux_in[0] = '0; uy_in[0] = '0; uu_in[0] = '0;
            a_in[0] = '{default: '0}; b_in[0] = '{default: '0};
         end else begin
            f_in[s] = f_ff[s-1]; rho_in[s] = rho_ff[s-1];
            jx_in[s] = jx_ff[s-1]; jy_in[s] = jy_ff[s-1];
            ux_in[s] = ux_ff[s-1]; uy_in[s] = uy_ff[s-1]; uu_in[s] = uu_ff[s-1];
            a_in[s] = a_ff[s-1]; b_in[s] = b_ff[s-1];
         end
      end
      // stage 0: moments over rest and axis directions, ordered saturating sums
      r = '0; x = '0; y = '0;
      for (int k = 0; k < 5; k++) begin
         r = sadd(r, f_in[0][k]);
         if (DX[k] > 0) x = sadd(x, f_in[0][k]);
         else if (DX[k] < 0) x = ssub(x, f_in[0][k]);
         if (DY[k] > 0) y = sadd(y, f_in[0][k]);
         else if (DY[k] < 0) y = ssub(y, f_in[0][k]);
      end
      rho_in[0] = r; jx_in[0] = x; jy_in[0] = y;
      // stage 1: moments continued over the diagonals
      r = rho_ff[0]; x = jx_ff[0]; y = jy_ff[0];
      for (int k = 5; k < NumDir; k++) begin
         r = sadd(r, f_ff[0][k]);
         if (DX[k] > 0) x = sadd(x, f_ff[0][k]);
         else if (DX[k] < 0) x = ssub(x, f_ff[0][k]);
         if (DY[k] > 0) y = sadd(y, f_ff[0][k]);
         else if (DY[k] < 0) y = ssub(y, f_ff[0][k]);
      end
      rho_in[1] = r; jx_in[1] = x; jy_in[1] = y;
      // stage 2: velocity
      ux_in[2] = smul(jx_ff[1], inv_ff);
      uy_in[2] = smul(jy_ff[1], inv_ff);
      // stage 3: squares
      uu_in[3] = smul(ux_ff[2], ux_ff[2]);
      a_in[3][0] = smul(uy_ff[2], uy_ff[2]);
      // stage 4: u.u and e.u per direction
      uu_in[4] = sadd(uu_ff[3], a_ff[3][0]);
      for (int k = 0; k < NumDir; k++) begin
         x = '0;
         if (DX[k] > 0) x = sadd(x, ux_ff[3]);
         else if (DX[k] < 0) x = ssub(x, ux_ff[3]);
         if (DY[k] > 0) x = sadd(x, uy_ff[3]);
         else if (DY[k] < 0) x = ssub(x, uy_ff[3]);
         a_in[4][k] = x;
      end
      // stage 5: 3 e.u and (e.u)^2; u.u*1.5
      for (int k = 0; k < NumDir; k++) begin
         a_in[5][k] = smul(a_ff[4][k], KThree);
         b_in[5][k] = smul(a_ff[4][k], a_ff[4][k]);
      end
      uu_in[5] = smul(uu_ff[4], KThreeHalf);
      // stage 6: 4.5 (e.u)^2
      for (int k = 0; k < NumDir; k++) b_in[6][k] = smul(b_ff[5][k], KNineHalf);
      // stage 7: bracket
      for (int k = 0; k < NumDir; k++)
         a_in[7][k] = ssub(sadd(a_ff[6][k], b_ff[6][k]), uu_ff[6]);
      // stage 8: rho0 * bracket + rho
      for (int k = 0; k < NumDir; k++)
         a_in[8][k] = sadd(rho_ff[7], smul(rho0_ff, a_ff[7][k]));
      // stage 9: equilibrium and non-equilibrium part
      for (int k = 0; k < NumDir; k++)
         a_in[9][k] = ssub(f_ff[8][k], smul(wgt(k), a_ff[8][k]));
      // stage 10: symmetric and antisymmetric halves
      for (int k = 0; k < NumDir; k++) begin
         a_in[10][k] = shalf(sadd(a_ff[9][k], a_ff[9][OPP[k]]));
         b_in[10][k] = shalf(ssub(a_ff[9][k], a_ff[9][OPP[k]]));
      end
      // stage 11: scale by the rates
      for (int k = 0; k < NumDir; k++) begin
         a_in[11][k] = smul(even_ff, a_ff[10][k]);
         b_in[11][k] = smul(odd_ff, b_ff[10][k]);
      end
      // stage 12: add even part
      for (int k = 0; k < NumDir; k++) a_in[12][k] = sadd(f_ff[11][k], a_ff[11][k]);
      // stage 13: add odd part
      for (int k = 0; k < NumDir; k++) a_in[13][k] = sadd(a_ff[12][k], b_ff[12][k]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in; rho_ff <= rho_in; jx_ff <= jx_in; jy_ff <= jy_in;
         ux_ff <= ux_in; uy_ff <= uy_in; uu_ff <= uu_in;
         a_ff <= a_in; b_ff <= b_in;
      end
   end

   // result port
   assign rsp_if.valid = vld_ff[Stages-1];
   assign rsp_if.post_rest  = a_ff[Stages-1][0];
   assign rsp_if.post_east  = a_ff[Stages-1][1];
   assign rsp_if.post_north = a_ff[Stages-1][2];
   assign rsp_if.post_west  = a_ff[Stages-1][3];
   assign rsp_if.post_south = a_ff[Stages-1][4];
   assign rsp_if.post_ne    = a_ff[Stages-1][5];
   assign rsp_if.post_nw    = a_ff[Stages-1][6];
   assign rsp_if.post_sw    = a_ff[Stages-1][7];
   assign rsp_if.post_se    = a_ff[Stages-1][8];
   assign rsp_if.density    = rho_ff[Stages-1];
   assign rsp_if.momentum_x = jx_ff[Stages-1];
   assign rsp_if.momentum_y = jy_ff[Stages-1];

   // a held result stays valid, with its density put, while the sink stalls
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.density))
      else $error("result changed under stall");
   // no item enters while the pipe is frozen
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |-> !req_if.ready)
      else $error("input taken during stall");
   // an accepted item enters the first stage
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && rsp_if.ready |=> vld_ff[0])
      else $error("item lost at entry");
endmodule
`default_nettype wire

>>> sim/tb_lbm_d2q9_trt_collision_core.sv
// testbench for the d2q9 two-relaxation-time collision core
`timescale 1ns / 100ps
module tb_lbm_d2q9_trt_collision_core;
   import lbm_pkg::*;

   typedef logic [11:0][DataWidth-1:0] post_vec_type;
   typedef logic [8:0][DataWidth-1:0] node_vec_type;

   typedef struct {
      node_vec_type vals;
      bit           typed;
      post_vec_type post;
   } node_row_type;

   localparam longint SatMax = 64'sd2147483647;
   localparam longint SatMin = -64'sd2147483648;
   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbm_node_if req_if ();
   lbm_post_if rsp_if ();
   lbm_csr_if csr_if ();

   lbm_d2q9_trt_collision_core u_dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   always #5 clock = ~clock;

   // lattice directions and opposites
   const int dir_ex[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   const int dir_ey[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
   const int dir_opp[9] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
   const string field_name[12] = '{"post_rest", "post_east", "post_north", "post_west",
      "post_south", "post_ne", "post_nw", "post_sw", "post_se", "density",
      "momentum_x", "momentum_y"};

   // predictor copy of the registers
   longint even_rate_q, odd_rate_q, rho0_q, inv_rho0_q;

   post_vec_type post_expected_q[$];
   bit        failed = 1'b0;
   bit        steady = 1'b0;
   int        cycles = 0;
   int        stall_left = 0;

   function automatic longint clamp_q(longint v);
      if (v > SatMax) return SatMax;
      if (v < SatMin) return SatMin;
      return v;
   endfunction

   // exact product, rounded half away from zero, saturated
   function automatic longint mul_q(longint a, longint b);
      longint p, m, q;
      p = a * b;
      m = (p < 0) ? -p : p;
      q = (m + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      if (p >= 0) return (q > SatMax) ? SatMax : q;
      return (q > -SatMin) ? SatMin : -q;
   endfunction

   // collision of one node with the current register values
   function automatic post_vec_type collide(node_vec_type fv);
      longint f[9], neq[9];
      longint rho, jx, jy, ux, uy, uu, eu, br, eq, sym, anti, p, wk;
      post_vec_type r;
      rho = 0; jx = 0; jy = 0;
      for (int k = 0; k < 9; k++) begin
         f[k] = longint'(signed'(fv[k]));
         rho = clamp_q(rho + f[k]);
         if (dir_ex[k] != 0) jx = clamp_q(jx + dir_ex[k] * f[k]);
         if (dir_ey[k] != 0) jy = clamp_q(jy + dir_ey[k] * f[k]);
      end
      ux = mul_q(jx, inv_rho0_q);
      uy = mul_q(jy, inv_rho0_q);
      uu = clamp_q(mul_q(ux, ux) + mul_q(uy, uy));
      for (int k = 0; k < 9; k++) begin
         eu = 0;
         if (dir_ex[k] != 0) eu = clamp_q(eu + dir_ex[k] * ux);
         if (dir_ey[k] != 0) eu = clamp_q(eu + dir_ey[k] * uy);
         br = clamp_q(mul_q(eu, longint'(KThree)) + mul_q(mul_q(eu, eu), longint'(KNineHalf)));
         br = clamp_q(br - mul_q(uu, longint'(KThreeHalf)));
         wk = (k == 0) ? longint'(KW0) : (k < 5) ? longint'(KW1) : longint'(KW2);
         eq = mul_q(wk, clamp_q(rho + mul_q(rho0_q, br)));
         neq[k] = clamp_q(f[k] - eq);
      end
      for (int k = 0; k < 9; k++) begin
         sym = mul_q(clamp_q(neq[k] + neq[dir_opp[k]]), 64'sd1 <<< (FracBits - 1));
         anti = mul_q(clamp_q(neq[k] - neq[dir_opp[k]]), 64'sd1 <<< (FracBits - 1));
         p = clamp_q(clamp_q(f[k] + mul_q(even_rate_q, sym)) + mul_q(odd_rate_q, anti));
         r[k] = p[DataWidth-1:0];
      end
      r[9] = rho[DataWidth-1:0];
      r[10] = jx[DataWidth-1:0];
      r[11] = jy[DataWidth-1:0];
      return r;
   endfunction

   // mostly short gaps, a few long, none during a steady stretch
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_reg(csr_addr_type idx, logic [DataWidth-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CsrEvenRate: even_rate_q = longint'(signed'(value[RateWidth-1:0]));
         CsrOddRate:  odd_rate_q = longint'(signed'(value[RateWidth-1:0]));
         CsrRestDens: rho0_q = longint'(value[DensWidth-1:0]);
         CsrInvRest:  inv_rho0_q = longint'(value[DensWidth-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic write_all(logic [DataWidth-1:0] ev, logic [DataWidth-1:0] od,
                            logic [DataWidth-1:0] rd, logic [DataWidth-1:0] ir);
      write_reg(CsrEvenRate, ev);
      write_reg(CsrOddRate, od);
      write_reg(CsrRestDens, rd);
      write_reg(CsrInvRest, ir);
   endtask

   // drive one node item, hold it until accepted, record the expectation
   // entered at a falling edge; valid stays high for a back-to-back follower
   task automatic send_node(node_vec_type fv, bit typed, post_vec_type post);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      {req_if.dist_se, req_if.dist_sw, req_if.dist_nw, req_if.dist_ne, req_if.dist_south,
       req_if.dist_west, req_if.dist_north, req_if.dist_east, req_if.dist_rest} <= fv;
      do @(posedge clock); while (!req_if.ready);
      post_expected_q.push_back(typed ? post : collide(fv));
      @(negedge clock);
   endtask

   // drop valid, then wait until every item has come out
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (post_expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [DataWidth-1:0] rand_val();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000 + 32'h0380_0000;
      if (r < 65) return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      if (r < 75) return $urandom_range(0, 1) ? VMax - $urandom_range(0, 3)
                                              : VMin + $urandom_range(0, 3);
      return $urandom();
   endfunction

   task automatic random_nodes(int count);
      node_vec_type d;
      int shape;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 49) == 0) steady = ~steady;
         shape = $urandom_range(0, 9);
         for (int k = 0; k < 9; k++) begin
            // near-equilibrium node around weight times a density near one
            if (shape < 6) d[k] = ((k == 0) ? KW0 : (k < 5) ? KW1 : KW2)
                                  + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            else d[k] = rand_val();
         end
         send_node(d, 1'b0, '0);
      end
      steady = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         post_vec_type got, want;
         got = {rsp_if.momentum_y, rsp_if.momentum_x, rsp_if.density, rsp_if.post_se,
                rsp_if.post_sw, rsp_if.post_nw, rsp_if.post_ne, rsp_if.post_south,
                rsp_if.post_west, rsp_if.post_north, rsp_if.post_east, rsp_if.post_rest};
         if (post_expected_q.size() == 0) begin
            $display("%0t: unexpected item %h", $time, got);
            failed = 1'b1;
         end else begin
            want = post_expected_q.pop_front();
            for (int i = 0; i < 12; i++)
               if (got[i] !== want[i]) begin
                  $display("%0t: %s expected %h actual %h", $time, field_name[i],
                           want[i], got[i]);
                  failed = 1'b1;
               end
         end
      end
   end

   // result side stalls, runs of random length
   always @(negedge clock) begin
      if (!reset && stall_left == 0) stall_left = pick_gap();
      if (reset || stall_left == 0) rsp_if.ready <= 1'b1;
      else begin
         rsp_if.ready <= 1'b0;
         stall_left = stall_left - 1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   node_row_type directed[$];

   initial begin
      node_row_type row;
      req_if.valid = 1'b0;
      {req_if.dist_se, req_if.dist_sw, req_if.dist_nw, req_if.dist_ne, req_if.dist_south,
       req_if.dist_west, req_if.dist_north, req_if.dist_east, req_if.dist_rest} = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CsrEvenRate;
      csr_if.data = '0;
      even_rate_q = -268435456;
      odd_rate_q = -306783378;
      rho0_q = 268435456;
      inv_rho0_q = 268435456;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed nodes: zero, extremes, bit patterns, rest direction alone, single directions, weights
      row.typed = 1'b1; row.post = '0; row.vals = '0;
      directed.push_back(row);
      row.typed = 1'b0; row.post = '0;
      row.vals = {9{VMax}}; directed.push_back(row);
      row.vals = {9{VMin}}; directed.push_back(row);
      row.vals = {9{32'hFFFF_FFFF}}; directed.push_back(row);
      row.vals = {9{32'h5555_5555}}; directed.push_back(row);
      row.vals = {9{32'hAAAA_AAAA}}; directed.push_back(row);
      row.vals = '0; row.vals[0] = 32'h1000_0000; directed.push_back(row);
      for (int k = 1; k < 9; k++) begin
         row.vals = '0; row.vals[k] = VMax; directed.push_back(row);
         row.vals = '0; row.vals[k] = VMin; directed.push_back(row);
      end
      row.vals = {KW2, KW2, KW2, KW2, KW1, KW1, KW1, KW1, KW0}; directed.push_back(row);
      foreach (directed[i]) send_node(directed[i].vals, directed[i].typed, directed[i].post);
      random_nodes(110);
      wait_idle();

      // extreme settings: one rate at its strongest, densities largest, then zero
      write_all(32'hE000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_nodes(110);
      wait_idle();
      write_all(32'h0000_0000, 32'hE000_0000, 32'h0000_0000, 32'h0000_0000);
      random_nodes(110);
      wait_idle();

      // in-range random settings
      write_all(-$urandom_range(0, 536870912), -$urandom_range(0, 536870912),
                $urandom_range(0, 32'h2000_0000), $urandom_range(0, 32'h2000_0000));
      random_nodes(110);
      wait_idle();

      // raw bit patterns, bits above the register widths included
      write_all($urandom(), $urandom(), $urandom(), $urandom());
      random_nodes(110);
      wait_idle();

      if (!failed) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

>>> lbm_d2q9_trt_collision_core.f
rtl/lbm_pkg.sv
rtl/lbm_intf.sv
rtl/lbm_d2q9_trt_collision_core.sv
sim/tb_lbm_d2q9_trt_collision_core.sv
